/* src/mf_pkg.sv */
// mf_pkg: shared types and constants of the window median filter
// beat layouts, configuration register map, parameter defaults
// no dependencies
package mf_pkg;

  localparam int PIX_W        = 8;
  localparam int IMG_W_W      = 12;
  localparam int WINDOW_DEF   = 3;
  localparam int LINE_MAX_DEF = 2048;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 12'd640;

  // apb configuration port
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_IDX_W = CFG_AW - 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = '0;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             window_valid;
  } res_beat_t;

  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
  } apb_req_t;

endpackage

/* src/mf_stream_if.sv */
// mf_stream_if: valid/ready stream channel carrying one beat type
// used for the pixel input and the result output
// no dependencies
interface mf_stream_if #(parameter type beat_t = logic);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/mf_ram.sv */
// mf_ram: generic single write port, single read port ram
// registered read with enable, read during write returns old data
// no dependencies
module mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* src/mf_cfg.sv */
// mf_cfg: apb register file of the median filter
// holds image_width
// depends on mf_pkg
module mf_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mf_pkg::apb_req_t            apb,
  output logic [mf_pkg::CFG_DW-1:0]   prdata,
  output logic                        pready,
  output logic [mf_pkg::IMG_W_W-1:0]  image_width
);
  import mf_pkg::*;

  logic [IMG_W_W-1:0]   image_width_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = apb.paddr[CFG_AW-1:2];
  assign wr_en   = apb.psel && apb.penable && apb.pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMG_W_RST;
    end else if (wr_en && (reg_idx == REG_IMAGE_WIDTH)) begin
      image_width_r <= apb.pwdata[IMG_W_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH: prdata = CFG_DW'(image_width_r);
      default:         prdata = '0;
    endcase
  end

  assign image_width = image_width_r;
endmodule

/* src/mf_line_buf.sv */
// mf_line_buf: row/column counting, line store rams and column tap stage
// emits one column of WINDOW taps per pixel, top row first
// depends on mf_pkg, mf_stream_if, mf_ram
module mf_line_buf #(
  parameter int WINDOW   = mf_pkg::WINDOW_DEF,
  parameter int LINE_MAX = mf_pkg::LINE_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [mf_pkg::IMG_W_W-1:0]  image_width,
  mf_stream_if.sink                   in_pix,
  output logic                        col_valid,
  input  logic                        col_ready,
  output logic [mf_pkg::PIX_W-1:0]    col_taps [WINDOW],
  output logic                        col_win_ok
);
  import mf_pkg::*;

  localparam int COL_W = $clog2(LINE_MAX);
  localparam int ROW_W = $clog2(WINDOW);
  localparam int EW    = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
  localparam int NL    = WINDOW - 1;

  localparam logic [EW-1:0]    LINE_MAX_E = EW'(LINE_MAX);
  localparam logic [COL_W-1:0] COL_FULL   = COL_W'(WINDOW - 1);
  localparam logic [ROW_W-1:0] ROW_FULL   = ROW_W'(WINDOW - 1);

  logic [COL_W-1:0] col_r, col_cur, col_nxt;
  logic [ROW_W-1:0] row_r, row_cur, row_nxt;
  logic [EW-1:0]    width_e, width_eff, col_inc;
  logic             accept, wrap, win_ok;

  logic             s1_v_r, s1_ok_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s2_v_r, s2_ok_r, fwd_r;
  logic [PIX_W-1:0] s2_px_r;
  logic [COL_W-1:0] s2_col_r;
  logic [PIX_W-1:0] fwd_data_r [NL];

  logic [PIX_W-1:0] ram_q    [NL];
  logic [PIX_W-1:0] ram_wdat [NL];
  logic [PIX_W-1:0] line_q   [NL];
  logic             s2_free, adv1, adv2;

  // effective width: zero acts as one, clamp to line store size
  assign width_e = EW'(image_width);
  always_comb begin
    priority if (width_e == '0) begin
      width_eff = EW'(1);
    end else if (width_e > LINE_MAX_E) begin
      width_eff = LINE_MAX_E;
    end else begin
      width_eff = width_e;
    end
  end

  assign accept  = in_pix.valid && in_pix.ready;
  assign col_cur = in_pix.data.frame_start ? '0 : col_r;
  assign row_cur = in_pix.data.frame_start ? '0 : row_r;
  assign win_ok  = (col_cur >= COL_FULL) && (row_cur == ROW_FULL);
  assign col_inc = EW'(col_cur) + EW'(1);
  assign wrap    = (col_inc >= width_eff);
  assign col_nxt = wrap ? '0 : col_inc[COL_W-1:0];
  assign row_nxt = (wrap && (row_cur != ROW_FULL)) ? row_cur + 1'b1 : row_cur;

  // pipeline handshake
  assign adv2         = s2_v_r && col_ready;
  assign s2_free      = !s2_v_r || col_ready;
  assign adv1         = s1_v_r && s2_free;
  assign in_pix.ready = !s1_v_r || adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_pix.ready) begin
        s1_v_r <= in_pix.valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
        fwd_r  <= adv2 && (s1_col_r == s2_col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.ready) begin
      s1_px_r  <= in_pix.data.pixel;
      s1_col_r <= col_cur;
      s1_ok_r  <= win_ok;
    end
    if (s2_free) begin
      s2_px_r  <= s1_px_r;
      s2_col_r <= s1_col_r;
      s2_ok_r  <= s1_ok_r;
      fwd_data_r <= ram_wdat;
    end
  end

  // line 0 holds the previous row, higher lines older rows
  for (genvar k = 0; k < NL; k++) begin : g_line
    if (k == 0) begin : g_first
      assign ram_wdat[k] = s2_px_r;
    end else begin : g_next
      assign ram_wdat[k] = line_q[k-1];
    end

    mf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LINE_MAX)
    ) u_ram (
      .clk   (clk),
      .we    (adv2),
      .waddr (s2_col_r),
      .wdata (ram_wdat[k]),
      .re    (adv1),
      .raddr (s1_col_r),
      .rdata (ram_q[k])
    );

    // same column written one beat earlier: ram returned stale data
    assign line_q[k]           = fwd_r ? fwd_data_r[k] : ram_q[k];
    assign col_taps[NL - 1 - k] = line_q[k];
  end

  assign col_taps[WINDOW-1] = s2_px_r;
  assign col_valid          = s2_v_r;
  assign col_win_ok         = s2_ok_r;
endmodule

/* src/mf_median.sv */
// mf_median: window register, rank stage and median select
// rank by counting smaller entries, select middle ranks, result register
// depends on mf_pkg, mf_stream_if
module mf_median #(
  parameter int WINDOW = mf_pkg::WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     col_valid,
  output logic                     col_ready,
  input  logic [mf_pkg::PIX_W-1:0] col_taps [WINDOW],
  input  logic                     col_win_ok,
  mf_stream_if.source              out_res
);
  import mf_pkg::*;

  localparam int N    = WINDOW * WINDOW;
  localparam int RK_W = $clog2(N);

  localparam logic [RK_W-1:0] MID_LO = RK_W'((N - 1) / 2);
  localparam logic [RK_W-1:0] MID_HI = RK_W'(N / 2);

  logic [PIX_W-1:0] win_r [WINDOW][WINDOW];
  logic             s3_v_r, s3_ok_r;
  logic [PIX_W-1:0] vals [N];
  logic [RK_W-1:0]  rank [N];
  logic [N-1:0]     m_lo, m_hi;

  logic             s4_v_r, s4_ok_r;
  logic [PIX_W-1:0] s4_val_r [N];
  logic [N-1:0]     s4_lo_r, s4_hi_r;
  logic [PIX_W-1:0] sel_lo, sel_hi;
  logic [PIX_W:0]   mid_sum;

  logic             out_v_r;
  res_beat_t        out_data_r;
  logic             s4_free, out_free, adv3;

  assign out_free  = !out_v_r || out_res.ready;
  assign s4_free   = !s4_v_r || out_free;
  assign adv3      = s3_v_r && s4_free;
  assign col_ready = !s3_v_r || adv3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (col_ready) begin
        s3_v_r <= col_valid;
      end
      if (s4_free) begin
        s4_v_r <= s3_v_r;
      end
      if (out_free) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  // window columns shift left, newest column enters at the right
  always_ff @(posedge clk) begin
    if (col_valid && col_ready) begin
      for (int c = 0; c < WINDOW - 1; c++) begin
        win_r[c] <= win_r[c+1];
      end
      win_r[WINDOW-1] <= col_taps;
      s3_ok_r         <= col_win_ok;
    end
  end

  always_comb begin
    for (int c = 0; c < WINDOW; c++) begin
      for (int r = 0; r < WINDOW; r++) begin
        vals[c*WINDOW + r] = win_r[c][r];
      end
    end
  end

  // rank = count of smaller entries, ties broken by position
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
      m_lo[i] = (rank[i] == MID_LO);
      m_hi[i] = (rank[i] == MID_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_free) begin
      s4_val_r <= vals;
      s4_lo_r  <= m_lo;
      s4_hi_r  <= m_hi;
      s4_ok_r  <= s3_ok_r;
    end
  end

  always_comb begin
    sel_lo = '0;
    sel_hi = '0;
    for (int i = 0; i < N; i++) begin
      if (s4_lo_r[i]) begin
        sel_lo = sel_lo | s4_val_r[i];
      end
      if (s4_hi_r[i]) begin
        sel_hi = sel_hi | s4_val_r[i];
      end
    end
    mid_sum = {1'b0, sel_lo} + {1'b0, sel_hi};
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r.median       <= s4_ok_r ? mid_sum[PIX_W:1] : '0;
      out_data_r.window_valid <= s4_ok_r;
    end
  end

  assign out_res.valid = out_v_r;
  assign out_res.data  = out_data_r;
endmodule

/* src/window_median_filter.sv */
// channel   | dir | beat                        | handshake
// in_pix    | in  | pixel, frame_start          | valid/ready
// out_res   | out | median, window_valid        | valid/ready
// apb cfg   | in  | image_width at byte addr 0  | psel/penable, pready high
//
// one pixel per cycle sustained while out_res does not stall; a result reaches
// out_res through the input register, the line store ram read stage, the
// window register, the rank register and the result register
// reset clears counters, stage valids and sets image_width to 640; line
// stores need no clearing pass
// out_res stalls fill the stages; in_pix.ready drops only when all are full
//
// top level of the window median filter; depends on mf_pkg, mf_stream_if,
// mf_ram, mf_cfg, mf_line_buf, mf_median
module window_median_filter #(
  parameter int WINDOW   = mf_pkg::WINDOW_DEF,
  parameter int LINE_MAX = mf_pkg::LINE_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mf_stream_if.sink                  in_pix,
  mf_stream_if.source                out_res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mf_pkg::CFG_AW-1:0]  paddr,
  input  logic [mf_pkg::CFG_DW-1:0]  pwdata,
  output logic [mf_pkg::CFG_DW-1:0]  prdata,
  output logic                       pready
);
  import mf_pkg::*;

  apb_req_t           apb;
  logic [IMG_W_W-1:0] image_width;
  logic               col_valid, col_ready, col_win_ok;
  logic [PIX_W-1:0]   col_taps [WINDOW];

  assign apb.psel    = psel;
  assign apb.penable = penable;
  assign apb.pwrite  = pwrite;
  assign apb.paddr   = paddr;
  assign apb.pwdata  = pwdata;

  mf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .apb         (apb),
    .prdata      (prdata),
    .pready      (pready),
    .image_width (image_width)
  );

  mf_line_buf #(
    .WINDOW   (WINDOW),
    .LINE_MAX (LINE_MAX)
  ) u_line_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_width (image_width),
    .in_pix      (in_pix),
    .col_valid   (col_valid),
    .col_ready   (col_ready),
    .col_taps    (col_taps),
    .col_win_ok  (col_win_ok)
  );

  mf_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .col_valid  (col_valid),
    .col_ready  (col_ready),
    .col_taps   (col_taps),
    .col_win_ok (col_win_ok),
    .out_res    (out_res)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.data.window_valid |-> out_res.data.median == '0)
    else $error("median not zero on invalid window");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_IMAGE_WIDTH)
    |=> image_width == $past(pwdata[IMG_W_W-1:0]))
    else $error("image_width write lost");

  a_tap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    col_valid && !col_ready |=> col_valid && $stable(col_taps[0])
      && $stable(col_win_ok))
    else $error("line store taps changed while stalled");
endmodule
